### sv/vpha_pkg.sv
// ----------------------------------------------------------------------------
// vpha_pkg: shared definitions for the hole allocator
// Field widths, item codes, register indexes and the cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package vpha_pkg;

    localparam int HOLES_DEF     = 16;
    localparam int SIZE_BITS_DEF = 16;

    localparam int FUNC_W     = 1;
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 4;
    localparam int LEFT_W     = 16;
    localparam int FREE_W     = 20;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [FREE_W-1:0] FREE_MAX = 20'hFFFFF;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_REQUEST = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd3;

    // placement policies; the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 1'b1;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/vpha_if.sv
// ----------------------------------------------------------------------------
// vpha_req_if / vpha_rsp_if: item channels of the hole allocator
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpha_req_if;
    logic                              valid;
    logic                              ready;
    logic [vpha_pkg::FUNC_W-1:0]       func;
    logic [vpha_pkg::SLOT_W-1:0]       hole_slot;
    logic [vpha_pkg::AMOUNT_W-1:0]     amount;

    modport source (output valid, output func, output hole_slot, output amount,
                    input ready);
    modport sink   (input valid, input func, input hole_slot, input amount,
                    output ready);
endinterface

interface vpha_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [vpha_pkg::STATUS_W-1:0]     status;
    logic [vpha_pkg::INDEX_W-1:0]      hole_index;
    logic [vpha_pkg::LEFT_W-1:0]       hole_left;
    logic [vpha_pkg::FREE_W-1:0]       free_total;

    modport source (output valid, output status, output hole_index,
                    output hole_left, output free_total, input ready);
    modport sink   (input valid, input status, input hole_index,
                    input hole_left, input free_total, output ready);
endinterface

`default_nettype wire

### sv/vpha_cell.sv
// ----------------------------------------------------------------------------
// vpha_cell: one hole slot of the allocator chain
// Holds one hole size; loads a new size or takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module vpha_cell #(
    parameter int SIZE_BITS = vpha_pkg::SIZE_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vpha_pkg::cell_ctrl_t ctrl,
    input  wire logic [SIZE_BITS-1:0] wr_data,
    input  wire logic [SIZE_BITS-1:0] nbr,
    output logic      [SIZE_BITS-1:0] size
);

    logic [SIZE_BITS-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (ctrl.wr)
        begin
            size_reg <= wr_data;
        end
        else if (ctrl.shift)
        begin
            size_reg <= nbr;
        end
    end

    assign size = size_reg;

endmodule

`default_nettype wire

### sv/variable_partition_hole_allocator.sv
// ----------------------------------------------------------------------------
// variable_partition_hole_allocator: first/best/worst fit hole allocator
// Keeps hole sizes in a ring of cells and serves load and request items.
// ----------------------------------------------------------------------------
// Usage:
//   req carries items in: func selects a load (write a hole's size) or a
//   request (allocate amount from a hole under the configured policy).
//   rsp returns one result item per item, load or request: status, chosen or loaded
//   slot, size left in it, and the free total over the slots in use.
//   cfg_wr_en/cfg_index/cfg_data write policy (index 0) and hole_count
//   (index 1); write them only while no item is in flight.
// Timing:
//   One item at a time. An item is taken in S_IDLE, then the hole ring
//   rotates once through the head cell (one slot per cycle), then the
//   update step, once the result register is free, updates the chosen hole
//   and fills the result register. A new item is taken only after the
//   update step, so the allocator never holds two items at once.
// Reset:
//   All hole sizes, the stop flag and both registers clear to zero.
// Stalls:
//   The result register holds while rsp.ready is low; the next item may still
//   be taken and scanned, and it waits at its update step until the register
//   frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_partition_hole_allocator #(
    parameter int HOLES     = vpha_pkg::HOLES_DEF,
    parameter int SIZE_BITS = vpha_pkg::SIZE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    vpha_req_if.sink                               req,
    vpha_rsp_if.source                             rsp,
    input  wire logic                              cfg_wr_en,
    input  wire logic [vpha_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vpha_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W = $clog2(HOLES + 1);
    localparam int SUM_W = SIZE_BITS + CNT_W;
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HOLES - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // configuration
    logic [vpha_pkg::POLICY_W-1:0] policy_reg;
    logic [vpha_pkg::COUNT_W-1:0]  hole_count_reg;

    // captured item
    logic [vpha_pkg::FUNC_W-1:0]   func_reg;
    logic [vpha_pkg::SLOT_W-1:0]   slot_reg;
    logic                          slot_ok_reg;
    logic [SIZE_BITS-1:0]          amt_reg;

    // scan bookkeeping
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] pick_left_reg;
    logic                 stopped_reg;

    // result register
    logic                            rsp_valid_reg;
    logic [vpha_pkg::STATUS_W-1:0]   status_reg;
    logic [vpha_pkg::INDEX_W-1:0]    index_reg;
    logic [vpha_pkg::LEFT_W-1:0]     left_reg;
    logic [vpha_pkg::FREE_W-1:0]     free_reg;

    // ring of hole cells
    logic [SIZE_BITS-1:0]  cell_size [HOLES];
    vpha_pkg::cell_ctrl_t  cell_ctrl [HOLES];
    logic [SIZE_BITS-1:0]  cell_wr_data;

    logic                 accept;
    logic                 slot_ok;
    logic                 load_wr;
    logic                 fin_go;
    logic                 pick_wr;
    logic [CNT_W-1:0]     n_use;
    logic [SIZE_BITS-1:0] head;
    logic                 in_use;
    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 take;
    logic [SUM_W-1:0]     sum_after;
    logic [vpha_pkg::FREE_W-1:0] free_sat;

    assign accept  = req.valid && req.ready;
    assign slot_ok = int'(req.hole_slot) < HOLES;
    assign load_wr = accept && (req.func == vpha_pkg::FUNC_LOAD) && slot_ok;

    // the update step waits for the result register to free up
    assign fin_go  = (state_reg == S_FIN) && (!rsp_valid_reg || rsp.ready);
    assign pick_wr = fin_go && (func_reg == vpha_pkg::FUNC_REQUEST) &&
                     !stopped_reg && found_reg;

    // a load writes its cell at acceptance, an allocation at the update step
    assign cell_wr_data = (state_reg == S_IDLE) ? SIZE_BITS'(req.amount) : pick_left_reg;

    genvar g;
    generate
        for (g = 0; g < HOLES; g++)
        begin : g_cell
            assign cell_ctrl[g].shift = (state_reg == S_SCAN);
            assign cell_ctrl[g].wr    = (load_wr && (int'(req.hole_slot) == g)) ||
                                        (pick_wr && (int'(pick_reg) == g));

            vpha_cell #(
                .SIZE_BITS (SIZE_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (cell_ctrl[g]),
                .wr_data (cell_wr_data),
                .nbr     (cell_size[(g + 1) % HOLES]),
                .size    (cell_size[g])
            );
        end
    endgenerate

    // slots in use, capped at the table depth
    assign n_use = (int'(hole_count_reg) > HOLES) ? CNT_W'(HOLES) : CNT_W'(hole_count_reg);

    // at scan step j the head cell shows hole j
    assign head   = cell_size[0];
    assign in_use = cnt_reg < n_use;
    assign fits   = in_use && (head >= amt_reg);
    assign left   = head - amt_reg;

    always_comb
    begin
        case (policy_reg)
            vpha_pkg::POL_BEST:  take = fits && (!found_reg || (left < pick_left_reg));
            vpha_pkg::POL_WORST: take = fits && (!found_reg || (left > pick_left_reg));
            default:             take = fits && !found_reg;
        endcase
    end

    assign sum_next  = sum_reg + (in_use ? SUM_W'(head) : SUM_W'(0));
    assign sum_after = pick_wr ? (sum_reg - SUM_W'(amt_reg)) : sum_reg;
    assign free_sat  = (sum_after > SUM_W'(vpha_pkg::FREE_MAX)) && (SUM_W > vpha_pkg::FREE_W)
                       ? vpha_pkg::FREE_MAX : vpha_pkg::FREE_W'(sum_after);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= vpha_pkg::POL_FIRST;
            hole_count_reg <= '0;
            stopped_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    vpha_pkg::REG_POLICY:     policy_reg     <= cfg_data[vpha_pkg::POLICY_W-1:0];
                    vpha_pkg::REG_HOLE_COUNT: hole_count_reg <= cfg_data;
                    default:                  ;
                endcase
            end

            if (accept)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (state_reg == S_SCAN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end

            // a request that fits nowhere stops all later requests
            if (fin_go && (func_reg == vpha_pkg::FUNC_REQUEST) && !found_reg)
            begin
                stopped_reg <= 1'b1;
            end

            if (fin_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            slot_reg    <= req.hole_slot;
            slot_ok_reg <= slot_ok;
            amt_reg     <= SIZE_BITS'(req.amount);
            sum_reg     <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            sum_reg <= sum_next;
            if (take)
            begin
                pick_reg      <= cnt_reg[IDX_W-1:0];
                pick_left_reg <= left;
            end
        end

        if (fin_go)
        begin
            free_reg <= free_sat;
            if (func_reg == vpha_pkg::FUNC_LOAD)
            begin
                status_reg <= vpha_pkg::ST_LOADED;
                index_reg  <= slot_reg;
                left_reg   <= slot_ok_reg ? vpha_pkg::LEFT_W'(amt_reg) : '0;
            end
            else if (stopped_reg)
            begin
                status_reg <= vpha_pkg::ST_REFUSED;
                index_reg  <= '0;
                left_reg   <= '0;
            end
            else if (!found_reg)
            begin
                status_reg <= vpha_pkg::ST_NO_FIT;
                index_reg  <= '0;
                left_reg   <= '0;
            end
            else
            begin
                status_reg <= vpha_pkg::ST_ALLOCATED;
                index_reg  <= vpha_pkg::INDEX_W'(pick_reg);
                left_reg   <= vpha_pkg::LEFT_W'(pick_left_reg);
            end
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.hole_index = index_reg;
    assign rsp.hole_left  = left_reg;
    assign rsp.free_total = free_reg;

endmodule

`default_nettype wire

### sv/vpha_checker.sv
// ----------------------------------------------------------------------------
// vpha_checker: port-level checks for the hole allocator
// Watches the item channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module vpha_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [vpha_pkg::STATUS_W-1:0]     rsp_status,
    input wire logic [vpha_pkg::INDEX_W-1:0]      rsp_hole_index,
    input wire logic [vpha_pkg::LEFT_W-1:0]       rsp_hole_left,
    input wire logic [vpha_pkg::FREE_W-1:0]       rsp_free_total
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_hole_index) && $stable(rsp_hole_left) && $stable(rsp_free_total))
        else $error("result changed while stalled");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input open right after an accepted item");

    // failure and refusal report no slot
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == vpha_pkg::ST_NO_FIT ||
                      rsp_status == vpha_pkg::ST_REFUSED)
        |-> rsp_hole_index == '0 && rsp_hole_left == '0)
        else $error("failed request reports a slot");

    // the allocated hole counts in the free total
    a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == vpha_pkg::ST_ALLOCATED
        |-> rsp_free_total >= vpha_pkg::FREE_W'(rsp_hole_left))
        else $error("free total below remaining hole size");

endmodule

bind variable_partition_hole_allocator vpha_checker u_vpha_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_hole_index (rsp.hole_index),
    .rsp_hole_left  (rsp.hole_left),
    .rsp_free_total (rsp.free_total)
);

`default_nettype wire
